[rtl/brp_pkg.sv]
// Shared types, constants and helpers for the barometer compensation pipeline.
package brp_pkg;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_COEFFS_A = 2'd0,
        CFG_COEFFS_B = 2'd1,
        CFG_COEFFS_C = 2'd2
    } cfg_index_t;

    // Fixed constants of the compensation formula
    localparam logic [31:0] T_ROUND    = 32'd8;
    localparam logic [31:0] B6_OFFSET  = 32'd4000;
    localparam logic [31:0] B4_OFFSET  = 32'd32768;
    localparam int unsigned B7_BASE    = 50000;
    localparam logic [31:0] P_SQ_COEF  = 32'd3038;
    localparam logic [31:0] P_LIN_COEF = 32'hFFFF_E331;  // -7375
    localparam logic [31:0] P_OFFSET   = 32'd3791;
    localparam logic [31:0] TEMP_MAX   = 32'h0000_7FFF;
    localparam logic [31:0] TEMP_MIN   = 32'hFFFF_8000;

    // Arithmetic right shift of a 32-bit pattern
    function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned n);
        return $signed(v) >>> n;
    endfunction

    // Sign-extend a 16-bit coefficient to 32 bits
    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    // Two's complement absolute value
    function automatic logic [31:0] abs32(input logic [31:0] v);
        return v[31] ? (32'd0 - v) : v;
    endfunction

endpackage

[rtl/barometer_raw_to_pressure_compensation.sv]
// Top level of the barometer raw-to-pressure compensation pipeline.
// Accepts one raw temperature/pressure request per cycle while the output is not stalled and
// returns one result per request, in order. The pipe holds two 32-stage pipelined dividers
// (temperature correction and pressure quotient) plus 13 arithmetic stages; throughput is one
// request per cycle when not stalled because every stage, including each divider bit, is
// registered. The whole pipe advances whenever the output register is empty or taken.
// Coefficients must be written while no request is in flight. A zero divisor returns
// divide_fault with both outputs zero.
module barometer_raw_to_pressure_compensation
    import brp_pkg::*;
#(
    parameter int OVERSAMPLING = 3
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // raw_temperature[15:0], raw_pressure[34:16], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // temperature_tenths[15:0], pressure_pa[47:16]
    output logic [0:0]  m_tuser,   // divide_fault[0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam logic [31:0] B7_SCALE = 32'(B7_BASE >> OVERSAMPLING);
    localparam int DIVA_PW = 19 + 32 + 2;
    localparam int DIVB_PW = 32 + 2;

    // Coefficient registers
    logic [63:0] coeffs_a_reg;
    logic [63:0] coeffs_b_reg;
    logic [47:0] coeffs_c_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeffs_a_reg <= '0;
            coeffs_b_reg <= '0;
            coeffs_c_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_COEFFS_A: coeffs_a_reg <= cfg_data;
                CFG_COEFFS_B: coeffs_b_reg <= cfg_data;
                CFG_COEFFS_C: coeffs_c_reg <= cfg_data[47:0];
                default: ;
            endcase
        end
    end

    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    assign ac1 = sx16(coeffs_a_reg[63:48]);
    assign ac2 = sx16(coeffs_a_reg[47:32]);
    assign ac3 = sx16(coeffs_a_reg[31:16]);
    assign ac4 = {16'd0, coeffs_a_reg[15:0]};
    assign ac5 = {16'd0, coeffs_b_reg[63:48]};
    assign ac6 = {16'd0, coeffs_b_reg[47:32]};
    assign b1  = sx16(coeffs_b_reg[31:16]);
    assign b2  = sx16(coeffs_b_reg[15:0]);
    assign mc  = sx16(coeffs_c_reg[31:16]);
    assign md  = sx16(coeffs_c_reg[15:0]);

    // Global advance: output empty or being taken
    logic adv;
    logic out_valid_reg;
    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;

    // Stage A..C: temperature pre-products
    logic        a_v_reg, b_v_reg, c_v_reg;
    logic [31:0] a_d_reg, b_m_reg, c_x1_reg;
    logic [18:0] a_up_reg, b_up_reg, c_up_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_v_reg <= s_tvalid;
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_d_reg  <= {16'd0, s_tdata[15:0]} - ac6;
            a_up_reg <= s_tdata[34:16];
            b_m_reg  <= 32'(a_d_reg * ac5);
            b_up_reg <= a_up_reg;
            c_x1_reg <= asr32(b_m_reg, 15);
            c_up_reg <= b_up_reg;
        end
    end

    // Temperature divider: (MC << 11) / (X1 + MD), signed via magnitudes
    logic [31:0]        den, num;
    logic [DIVA_PW-1:0] diva_pl_in, diva_pl_out;
    logic               diva_v;
    logic [31:0]        diva_q;

    assign den        = c_x1_reg + md;
    assign num        = mc << 11;
    assign diva_pl_in = {c_up_reg, c_x1_reg, den[31] ^ num[31], den == 32'd0};

    brp_udiv_pipe #(.W(32), .PW(DIVA_PW)) u_div_temp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (adv),
        .in_valid    (c_v_reg),
        .dividend    (abs32(num)),
        .divisor     (abs32(den)),
        .in_payload  (diva_pl_in),
        .out_valid   (diva_v),
        .quotient    (diva_q),
        .out_payload (diva_pl_out)
    );

    logic [18:0] da_up;
    logic [31:0] da_x1, da_x2, da_sum;
    logic        da_neg, da_fault;
    assign {da_up, da_x1, da_neg, da_fault} = diva_pl_out;
    assign da_x2  = da_neg ? (32'd0 - diva_q) : diva_q;
    assign da_sum = da_x1 + da_x2;

    // Stages D..I: pressure coefficients B3, B4 inputs, B7
    logic        d_v_reg, e_v_reg, f_v_reg, g_v_reg, h_v_reg, i_v_reg;
    logic [31:0] d_t_reg, e_t_reg, f_t_reg, g_t_reg, h_t_reg, i_t_reg;
    logic        d_f_reg, e_f_reg, f_f_reg, g_f_reg, h_f_reg, i_f_reg;
    logic [18:0] d_up_reg, e_up_reg, f_up_reg, g_up_reg, h_up_reg;
    logic [31:0] d_b6_reg;
    logic [31:0] e_sq_reg, e_a2_reg, e_a3_reg;
    logic [31:0] f_sq_reg, f_x2a_reg, f_x1c_reg;
    logic [31:0] g_sqb2_reg, g_sqb1_reg, g_x2a_reg, g_x1c_reg;
    logic [31:0] h_b3_reg, h_y_reg;
    logic [31:0] i_prod_reg, i_b7_reg;
    logic [31:0] h_x3, h_b3_pre, h_x3b;

    assign h_x3     = asr32(g_sqb2_reg, 11) + g_x2a_reg;
    assign h_b3_pre = (((ac1 << 2) + h_x3) << OVERSAMPLING) + 32'd2;
    assign h_x3b    = asr32(g_x1c_reg + asr32(g_sqb1_reg, 16) + 32'd2, 2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_v_reg <= 1'b0;
            e_v_reg <= 1'b0;
            f_v_reg <= 1'b0;
            g_v_reg <= 1'b0;
            h_v_reg <= 1'b0;
            i_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            d_v_reg <= diva_v;
            e_v_reg <= d_v_reg;
            f_v_reg <= e_v_reg;
            g_v_reg <= f_v_reg;
            h_v_reg <= g_v_reg;
            i_v_reg <= h_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_t_reg    <= asr32(da_sum + T_ROUND, 4);
            d_b6_reg   <= da_sum - B6_OFFSET;
            d_f_reg    <= da_fault;
            d_up_reg   <= da_up;

            e_sq_reg   <= 32'(d_b6_reg * d_b6_reg);
            e_a2_reg   <= 32'(ac2 * d_b6_reg);
            e_a3_reg   <= 32'(ac3 * d_b6_reg);
            e_t_reg    <= d_t_reg;
            e_f_reg    <= d_f_reg;
            e_up_reg   <= d_up_reg;

            f_sq_reg   <= asr32(e_sq_reg, 12);
            f_x2a_reg  <= asr32(e_a2_reg, 11);
            f_x1c_reg  <= asr32(e_a3_reg, 13);
            f_t_reg    <= e_t_reg;
            f_f_reg    <= e_f_reg;
            f_up_reg   <= e_up_reg;

            g_sqb2_reg <= 32'(f_sq_reg * b2);
            g_sqb1_reg <= 32'(f_sq_reg * b1);
            g_x2a_reg  <= f_x2a_reg;
            g_x1c_reg  <= f_x1c_reg;
            g_t_reg    <= f_t_reg;
            g_f_reg    <= f_f_reg;
            g_up_reg   <= f_up_reg;

            h_b3_reg   <= asr32(h_b3_pre, 2);
            h_y_reg    <= h_x3b + B4_OFFSET;
            h_t_reg    <= g_t_reg;
            h_f_reg    <= g_f_reg;
            h_up_reg   <= g_up_reg;

            i_prod_reg <= 32'(ac4 * h_y_reg);
            i_b7_reg   <= 32'(({13'd0, h_up_reg} - h_b3_reg) * B7_SCALE);
            i_t_reg    <= h_t_reg;
            i_f_reg    <= h_f_reg;
        end
    end

    // Pressure divider: unsigned B7 / B4 with the doubling before or after
    logic [31:0]        b4;
    logic [DIVB_PW-1:0] divb_pl_in, divb_pl_out;
    logic               divb_v;
    logic [31:0]        divb_q;

    assign b4         = i_prod_reg >> 15;
    assign divb_pl_in = {i_t_reg, i_f_reg || (b4 == 32'd0), i_b7_reg[31]};

    brp_udiv_pipe #(.W(32), .PW(DIVB_PW)) u_div_pres
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (adv),
        .in_valid    (i_v_reg),
        .dividend    (i_b7_reg[31] ? i_b7_reg : (i_b7_reg << 1)),
        .divisor     (b4),
        .in_payload  (divb_pl_in),
        .out_valid   (divb_v),
        .quotient    (divb_q),
        .out_payload (divb_pl_out)
    );

    logic [31:0] db_t;
    logic        db_fault, db_post;
    assign {db_t, db_fault, db_post} = divb_pl_out;

    // Stages J..L: final pressure correction
    logic        j_v_reg, k_v_reg, l_v_reg;
    logic [31:0] j_p_reg, k_p_reg, l_p_reg;
    logic [31:0] j_t_reg, k_t_reg, l_t_reg;
    logic        j_f_reg, k_f_reg, l_f_reg;
    logic [31:0] k_aa_reg, k_pm_reg, l_x1_reg, l_x2_reg;
    logic [31:0] j_a;

    assign j_a = asr32(j_p_reg, 8);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            j_v_reg <= 1'b0;
            k_v_reg <= 1'b0;
            l_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            j_v_reg <= divb_v;
            k_v_reg <= j_v_reg;
            l_v_reg <= k_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            j_p_reg  <= db_post ? (divb_q << 1) : divb_q;
            j_t_reg  <= db_t;
            j_f_reg  <= db_fault;

            k_aa_reg <= 32'(j_a * j_a);
            k_pm_reg <= 32'(P_LIN_COEF * j_p_reg);
            k_p_reg  <= j_p_reg;
            k_t_reg  <= j_t_reg;
            k_f_reg  <= j_f_reg;

            l_x1_reg <= 32'(k_aa_reg * P_SQ_COEF);
            l_x2_reg <= asr32(k_pm_reg, 16);
            l_p_reg  <= k_p_reg;
            l_t_reg  <= k_t_reg;
            l_f_reg  <= k_f_reg;
        end
    end

    // Output register: pressure sum, temperature saturation, fault zeroing
    logic [31:0] p_final;
    logic [15:0] t_sat;
    logic [15:0] out_temp_reg;
    logic [31:0] out_pres_reg;
    logic        out_fault_reg;

    assign p_final = l_p_reg + asr32(asr32(l_x1_reg, 16) + l_x2_reg + P_OFFSET, 4);

    always_comb
    begin
        if ($signed(l_t_reg) > $signed(TEMP_MAX))
        begin
            t_sat = TEMP_MAX[15:0];
        end
        else if ($signed(l_t_reg) < $signed(TEMP_MIN))
        begin
            t_sat = TEMP_MIN[15:0];
        end
        else
        begin
            t_sat = l_t_reg[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= l_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_temp_reg  <= l_f_reg ? 16'd0 : t_sat;
            out_pres_reg  <= l_f_reg ? 32'd0 : p_final;
            out_fault_reg <= l_f_reg;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {out_pres_reg, out_temp_reg};
    assign m_tuser[0] = out_fault_reg;

    // Checks
    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == 48'd0))
        else $error("faulted result carries nonzero data");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> a_v_reg)
        else $error("accepted request missing from first stage");

    a_div_order: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && diva_v) |=> d_v_reg)
        else $error("temperature divider output lost");

endmodule

[rtl/brp_udiv_pipe.sv]
// Fully pipelined unsigned restoring divider, one quotient bit per stage.
module brp_udiv_pipe
#(
    parameter int W  = 32,
    parameter int PW = 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [W-1:0]  dividend,
    input  logic [W-1:0]  divisor,
    input  logic [PW-1:0] in_payload,
    output logic          out_valid,
    output logic [W-1:0]  quotient,
    output logic [PW-1:0] out_payload
);

    logic [W-1:0]  rem_reg [W];
    logic [W-1:0]  q_reg   [W];
    logic [W-1:0]  dv_reg  [W];
    logic [PW-1:0] pl_reg  [W];
    logic [W-1:0]  vld_reg;

    genvar k;
    generate
        for (k = 0; k < W; k++)
        begin : g_stage
            logic [W-1:0]  rem_in;
            logic [W-1:0]  q_in;
            logic [W-1:0]  dv_in;
            logic [PW-1:0] pl_in;
            logic          v_in;
            logic [W:0]    trial;
            logic          ge;
            logic [W-1:0]  rem_next;
            logic [W-1:0]  q_next;

            if (k == 0)
            begin : g_first
                assign rem_in = '0;
                assign q_in   = dividend;
                assign dv_in  = divisor;
                assign pl_in  = in_payload;
                assign v_in   = in_valid;
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[k-1];
                assign q_in   = q_reg[k-1];
                assign dv_in  = dv_reg[k-1];
                assign pl_in  = pl_reg[k-1];
                assign v_in   = vld_reg[k-1];
            end

            // shift in next dividend bit, subtract if it fits
            always_comb
            begin
                trial    = {rem_in, q_in[W-1]};
                ge       = (trial >= {1'b0, dv_in});
                rem_next = ge ? W'(trial - {1'b0, dv_in}) : trial[W-1:0];
                q_next   = {q_in[W-2:0], ge};
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[k] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= rem_next;
                    q_reg[k]   <= q_next;
                    dv_reg[k]  <= dv_in;
                    pl_reg[k]  <= pl_in;
                end
            end
        end
    endgenerate

    assign out_valid   = vld_reg[W-1];
    assign quotient    = q_reg[W-1];
    assign out_payload = pl_reg[W-1];

endmodule

[verif/testbench.sv]
// Self-checking testbench for the barometer raw-to-pressure compensation pipeline.
`timescale 1ns / 1ps

module testbench;
    import brp_pkg::*;

    typedef struct packed {
        logic [15:0] temp_tenths;
        logic [31:0] pressure;
        logic        fault;
    } comp_result_t;

    // Scoreboard: predicts compensation results and checks them in order
    class comp_scoreboard;
        logic [63:0] coef_a;
        logic [63:0] coef_b;
        logic [47:0] coef_c;
        comp_result_t pending_q[$];
        int errors;
        int checked;

        function new();
            coef_a = '0;
            coef_b = '0;
            coef_c = '0;
            errors = 0;
            checked = 0;
        endfunction

        function void write_coeffs(cfg_index_t idx, logic [63:0] value);
            case (idx)
                CFG_COEFFS_A: coef_a = value;
                CFG_COEFFS_B: coef_b = value;
                CFG_COEFFS_C: coef_c = value[47:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] sra(logic [31:0] v, int n);
            return $signed(v) >>> n;
        endfunction

        function logic [31:0] ext16(logic [15:0] v);
            return {{16{v[15]}}, v};
        endfunction

        function logic [31:0] div_trunc(logic [31:0] a, logic [31:0] b);
            logic [31:0] ua;
            logic [31:0] ub;
            logic [31:0] q;
            ua = a[31] ? -a : a;
            ub = b[31] ? -b : b;
            q = ua / ub;
            return (a[31] != b[31]) ? -q : q;
        endfunction

        function comp_result_t compensate(logic [15:0] ut, logic [18:0] up);
            comp_result_t r;
            logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
            logic [31:0] x1, x2, x3, den, t, b6, b3, b4, b7, p, sq;
            ac1 = ext16(coef_a[63:48]);
            ac2 = ext16(coef_a[47:32]);
            ac3 = ext16(coef_a[31:16]);
            ac4 = {16'd0, coef_a[15:0]};
            ac5 = {16'd0, coef_b[63:48]};
            ac6 = {16'd0, coef_b[47:32]};
            b1 = ext16(coef_b[31:16]);
            b2 = ext16(coef_b[15:0]);
            mc = ext16(coef_c[31:16]);
            md = ext16(coef_c[15:0]);
            r = '{temp_tenths: 16'd0, pressure: 32'd0, fault: 1'b1};
            x1 = sra(({16'd0, ut} - ac6) * ac5, 15);
            den = x1 + md;
            if (den == 0)
                return r;
            x2 = div_trunc(mc << 11, den);
            t = sra(x1 + x2 + 32'd8, 4);
            b6 = x1 + x2 - 32'd4000;
            sq = sra(b6 * b6, 12);
            x1 = sra(sq * b2, 11);
            x2 = sra(ac2 * b6, 11);
            x3 = x1 + x2;
            b3 = sra((((ac1 << 2) + x3) << 3) + 32'd2, 2);
            x1 = sra(ac3 * b6, 13);
            x2 = sra(sq * b1, 16);
            x3 = sra(x1 + x2 + 32'd2, 2);
            b4 = (ac4 * (x3 + 32'd32768)) >> 15;
            if (b4 == 0)
                return r;
            b7 = ({13'd0, up} - b3) * (32'd50000 >> 3);
            if (!b7[31])
                p = (b7 << 1) / b4;
            else
                p = (b7 / b4) << 1;
            x1 = sra(p, 8) * sra(p, 8);
            x1 = sra(x1 * 32'd3038, 16);
            x2 = sra(32'hFFFF_E331 * p, 16);
            p = p + sra(x1 + x2 + 32'd3791, 4);
            // saturate temperature to 16 bits
            if ($signed(t) > 32767)
                r.temp_tenths = 16'h7FFF;
            else if ($signed(t) < -32768)
                r.temp_tenths = 16'h8000;
            else
                r.temp_tenths = t[15:0];
            r.pressure = p;
            r.fault = 1'b0;
            return r;
        endfunction

        function void note_request(logic [15:0] ut, logic [18:0] up);
            pending_q.push_back(compensate(ut, up));
        endfunction

        function void check_result(logic [47:0] data, logic fault);
            comp_result_t want;
            checked++;
            if (pending_q.size() == 0)
            begin
                $error("unexpected result: data=%h fault=%b", data, fault);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            if (data[15:0] !== want.temp_tenths)
            begin
                $error("temperature_tenths: expected %0d actual %0d",
                       $signed(want.temp_tenths), $signed(data[15:0]));
                errors++;
            end
            if (data[47:16] !== want.pressure)
            begin
                $error("pressure_pa: expected %0d actual %0d",
                       $signed(want.pressure), $signed(data[47:16]));
                errors++;
            end
            if (fault !== want.fault)
            begin
                $error("divide_fault: expected %b actual %b", want.fault, fault);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    comp_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int sent;

    barometer_raw_to_pressure_compensation dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Receiver: random stall, check each accepted result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser[0]);
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Write one coefficient register; the caller drops cfg_valid afterwards
    task automatic write_reg(cfg_index_t idx, logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        sb.write_coeffs(idx, value);
    endtask

    task automatic load_coeffs(logic [63:0] a, logic [63:0] b, logic [47:0] c);
        write_reg(CFG_COEFFS_A, a);
        write_reg(CFG_COEFFS_B, b);
        write_reg(CFG_COEFFS_C, {16'd0, c});
        cfg_valid <= 1'b0;
    endtask

    // Send one raw sample request, with optional idle cycles first
    task automatic send_sample(logic [15:0] ut, logic [18:0] up);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, up, ut};
        do @(posedge clk); while (!s_tready);
        sb.note_request(ut, up);
        sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    // Typical factory calibration set
    localparam logic [63:0] TYP_A = {16'd408, 16'hFEB8, 16'hC7D1, 16'd32741};
    localparam logic [63:0] TYP_B = {16'd32757, 16'd23153, 16'd6190, 16'd4};
    localparam logic [47:0] TYP_C = {16'h8000, 16'hD4BD, 16'd2868};

    initial
    begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        logic [15:0] ut;
        logic [18:0] up;
        sb = new();
        sent = 0;
        send_idle_pct = 33;
        recv_idle_pct = 67;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_COEFFS_A;
        cfg_data = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset coefficients: zero divisor faults
        send_sample(16'd27898, 19'd23843);
        drain();

        // Typical calibration, field extremes
        load_coeffs(TYP_A, TYP_B, TYP_C);
        send_sample(16'd27898, 19'd23843);
        send_sample(16'd0, 19'd0);
        send_sample(16'hFFFF, 19'h7FFFF);
        send_sample(16'hFFFF, 19'd0);
        send_sample(16'd0, 19'h7FFFF);
        send_sample(16'h5555, 19'h2AAAA);
        send_sample(16'hAAAA, 19'h55555);
        drain();

        // Temperature divisor zero: AC5 = 0 and MD = 0
        load_coeffs(TYP_A, {16'd0, TYP_B[47:0]}, {TYP_C[47:16], 16'd0});
        send_sample(16'd1234, 19'd5678);
        drain();

        // Pressure divisor zero: AC4 = 0
        load_coeffs({TYP_A[63:16], 16'd0}, TYP_B, TYP_C);
        send_sample(16'd27898, 19'd23843);
        drain();

        // All-ones and extreme signed coefficients, saturating temperature
        load_coeffs('1, '1, '1);
        send_sample(16'd0, 19'h7FFFF);
        send_sample(16'hFFFF, 19'd1);
        drain();
        load_coeffs(64'h7FFF_7FFF_7FFF_FFFF, 64'hFFFF_0000_7FFF_7FFF,
                    48'h7FFF_7FFF_0001);
        send_sample(16'hFFFF, 19'h7FFFF);
        send_sample(16'd0, 19'd0);
        send_sample(16'd100, 19'd300000);
        drain();
        load_coeffs(64'h8000_8000_8000_FFFF, 64'hFFFF_FFFF_8000_8000,
                    48'h8000_8000_8001);
        send_sample(16'hFFFF, 19'h7FFFF);
        send_sample(16'd0, 19'd12345);
        drain();

        // Random phases: sender/receiver idling profiles
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 33 : (ph == 1) ? 67 : 0;
            recv_idle_pct = (ph == 0) ? 67 : (ph == 1) ? 33 : 0;
            for (int blk = 0; blk < 5; blk++)
            begin
                if (blk == 0)
                    load_coeffs(TYP_A, TYP_B, TYP_C);
                else if (blk == 4)
                    load_coeffs({$urandom, $urandom}, {$urandom, $urandom},
                                48'({$urandom, $urandom}));
                else
                    // perturb typical set for realistic but varied results
                    load_coeffs(TYP_A ^ {8'd0, 8'($urandom_range(255)), 16'd0,
                                         8'd0, 8'($urandom_range(255)), 16'd0},
                                TYP_B ^ {32'd0, 8'd0, 8'($urandom_range(255)), 16'd0},
                                TYP_C ^ {8'd0, 16'($urandom_range(255)), 8'd0, 16'd0});
                for (int k = 0; k < 30; k++)
                begin
                    if ($urandom_range(3) == 0)
                    begin
                        ut = 16'($urandom);
                        up = 19'($urandom);
                    end
                    else
                    begin
                        ut = 16'($urandom_range(32000, 24000));
                        up = 19'($urandom_range(60000, 10000));
                    end
                    send_sample(ut, up);
                end
                drain();
            end
        end

        $display("Covered %0d requests, %0d results checked, across reset, typical,", sent,
                 sb.checked);
        $display("extreme and random coefficients with three stall profiles.");
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[files.f]
rtl/brp_pkg.sv
rtl/brp_udiv_pipe.sv
rtl/barometer_raw_to_pressure_compensation.sv
verif/testbench.sv
